>>> rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants of the button click classifier
// Holds event codes, configuration register indexes, reset values and the
// structs passed between the top level and the classify logic.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned WINDOW_W   = 16;
  localparam int unsigned EVENT_W    = 3;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE     = 3'd0,
    EV_SINGLE   = 3'd1,
    EV_PRESSED  = 3'd2,
    EV_RELEASED = 3'd3,
    EV_DOUBLE   = 3'd4
  } bcc_event_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_CLICK  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRESSED_LEVEL = 2'd2;

  localparam logic [WINDOW_W-1:0] DEBOUNCE_RESET     = 16'd50;
  localparam logic [WINDOW_W-1:0] DOUBLE_CLICK_RESET = 16'd300;
  localparam logic                PRESSED_LEVEL_RESET = 1'b1;

  typedef struct packed {
    logic [WINDOW_W-1:0] debounce_ms;
    logic [WINDOW_W-1:0] double_click_ms;
    logic                pressed_level;
  } bcc_cfg_t;

  // The debounced pressed status doubles as the reported pressed flag; the
  // two always change together.
  typedef struct packed {
    logic              pressed;
    logic [TIME_W-1:0] press_time;
    logic [TIME_W-1:0] release_time;
    logic              armed;
    logic              double_on_release;
  } bcc_state_t;

endpackage

>>> rtl/bcc_in_if.sv
// ----------------------------------------------------------------------------
// bcc_in_if: sample channel of the button click classifier
// Carries one button sample per transfer: level, timestamp and arm request.
// ----------------------------------------------------------------------------
interface bcc_in_if;
  logic        valid;
  logic        ready;
  logic        level;
  logic [31:0] now_ms;
  logic        arm_double;

  modport source (output valid, output level, output now_ms, output arm_double,
                  input ready);
  modport sink (input valid, input level, input now_ms, input arm_double,
                output ready);
endinterface

>>> rtl/bcc_out_if.sv
// ----------------------------------------------------------------------------
// bcc_out_if: event channel of the button click classifier
// Carries one classified event and the debounced pressed status per transfer.
// ----------------------------------------------------------------------------
interface bcc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic       is_pressed;

  modport source (output valid, output event_res, output is_pressed, input ready);
  modport sink (input valid, input event_res, input is_pressed, output ready);
endinterface

>>> rtl/bcc_classify.sv
// ----------------------------------------------------------------------------
// bcc_classify: per-sample event decision
// Combinational next state and event for one registered sample.
// ----------------------------------------------------------------------------
module bcc_classify (
  input  bcc_pkg::bcc_cfg_t   cfg,
  input  bcc_pkg::bcc_state_t st,
  input  logic                level,
  input  logic [31:0]         now_ms,
  input  logic                arm_double,
  output bcc_pkg::bcc_state_t st_next,
  output bcc_pkg::bcc_event_t ev
);
  import bcc_pkg::*;

  logic              down;
  logic [TIME_W-1:0] since_rel;
  logic [TIME_W-1:0] since_press;
  logic [TIME_W-1:0] debounce_w;
  logic [TIME_W-1:0] window_w;

  assign down        = (level == cfg.pressed_level);
  assign since_rel   = now_ms - st.release_time;
  assign since_press = now_ms - st.press_time;
  assign debounce_w  = {{(TIME_W-WINDOW_W){1'b0}}, cfg.debounce_ms};
  assign window_w    = {{(TIME_W-WINDOW_W){1'b0}}, cfg.double_click_ms};

  // Checks run in order; a later one overrides the event of an earlier one.
  always_comb begin
    st_next       = st;
    st_next.armed = st.armed | arm_double;
    ev            = EV_NONE;

    if (since_rel > window_w && st_next.armed && !st.double_on_release) begin
      st_next.armed = 1'b0;
      ev            = EV_SINGLE;
    end

    if (since_rel >= debounce_w && down && !st.pressed) begin
      st_next.press_time        = now_ms;
      st_next.pressed           = 1'b1;
      st_next.double_on_release = st_next.armed && (since_rel < window_w);
      ev                        = EV_PRESSED;
    end

    // Press and release need opposite levels, so at most one of them fires.
    if (since_press >= debounce_w && !down && st.pressed) begin
      st_next.release_time = now_ms;
      st_next.pressed      = 1'b0;
      ev                   = EV_RELEASED;
      if (st.double_on_release) begin
        st_next.double_on_release = 1'b0;
        st_next.armed             = 1'b0;
        ev                        = EV_DOUBLE;
      end
    end
  end

endmodule

>>> rtl/button_click_classifier.sv
// A sample accepted into the input register moves on to the result register,
// which drives the event channel. Throughput: one sample per cycle unless a result
// stalls; the state is read and rewritten as a sample leaves the input register.
// Reset (synchronous, active high) empties both registers, clears the button
// state and loads the register defaults: debounce 50 ms, double-click 300 ms,
// pressed level 1.
// ----------------------------------------------------------------------------
// button_click_classifier: debounced button with single/double click events
// Classifies each timestamped pin sample as none, single, pressed, released
// or double, with a configurable debounce time and double-click window.
// ----------------------------------------------------------------------------
module button_click_classifier (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bcc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]      cfg_data,
  bcc_in_if.sink                              in_ch,
  bcc_out_if.source                           out_ch
);
  import bcc_pkg::*;

  // Configuration registers.
  bcc_cfg_t   cfg;

  // Input register: one sample waiting to be classified.
  logic              s1_valid;
  logic              s1_level;
  logic [TIME_W-1:0] s1_now;
  logic              s1_arm;

  // Button state, updated when a sample leaves the input register.
  bcc_state_t st;
  bcc_state_t st_next;
  bcc_event_t ev;

  // Result register.
  logic               out_valid;
  logic [EVENT_W-1:0] out_event;
  logic               out_pressed;

  logic advance;

  // The result register takes a new result whenever it is empty or its
  // current one is transferred in this cycle. The input register refills
  // whenever it is empty or moves on, so a waiting result blocks the next
  // sample only while the input register is also full.
  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || advance;

  assign out_ch.valid      = out_valid;
  assign out_ch.event_res  = out_event;
  assign out_ch.is_pressed = out_pressed;

  bcc_classify u_classify (
    .cfg        (cfg),
    .st         (st),
    .level      (s1_level),
    .now_ms     (s1_now),
    .arm_double (s1_arm),
    .st_next    (st_next),
    .ev         (ev)
  );

  // Control, configuration and button state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= DEBOUNCE_RESET;
      cfg.double_click_ms <= DOUBLE_CLICK_RESET;
      cfg.pressed_level   <= PRESSED_LEVEL_RESET;
      s1_valid            <= 1'b0;
      out_valid           <= 1'b0;
      st                  <= '0;
    end else begin
      // Writes to an index beyond the register list are dropped.
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEBOUNCE:      cfg.debounce_ms     <= cfg_data;
          CFG_DOUBLE_CLICK:  cfg.double_click_ms <= cfg_data;
          CFG_PRESSED_LEVEL: cfg.pressed_level   <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_ch.ready) begin
        s1_valid <= in_ch.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          st <= st_next;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_level <= in_ch.level;
      s1_now   <= in_ch.now_ms;
      s1_arm   <= in_ch.arm_double;
    end
    if (advance && s1_valid) begin
      out_event   <= ev;
      out_pressed <= st_next.pressed;
    end
  end

endmodule

>>> rtl/bcc_checker.sv
// ----------------------------------------------------------------------------
// bcc_checker: port-level checks for the button click classifier
// Watches the event channel and reset behavior at the top level's ports.
// ----------------------------------------------------------------------------
module bcc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_res,
  input logic       is_pressed
);
  import bcc_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // An empty result side never holds back the sample side.
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("sample refused while result register empty");

  // The pressed status agrees with the edge that was reported.
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_PRESSED) |-> is_pressed)
    else $error("pressed event without pressed status");

  a_status_rel: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_RELEASED || event_res == EV_DOUBLE) |-> !is_pressed)
    else $error("release event with pressed status");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .event_res  (out_ch.event_res),
  .is_pressed (out_ch.is_pressed)
);

>>> bench/tb_button_click_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_click_classifier: self-checking bench for the click classifier
// Drives timestamped button samples through the sample channel and checks
// every event transfer against a cycle-free model of the debounce and
// double-click rules. Register settings change between phases, both channels
// idle at random, and one long receiver hold-off backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_button_click_classifier;
  import bcc_pkg::*;

  // Random samples per register phase; eight phases give roughly 1960 samples.
  localparam int unsigned SAMPLES_PER_PHASE = 245;
  localparam int unsigned PHASES            = 8;
  // Length of the forced receiver hold-off, in clock cycles.
  localparam int unsigned HOLD_CYCLES       = 400;
  // Hard stop, far beyond the slowest correct run.
  localparam int unsigned TIMEOUT_NS        = 2_000_000;

  // One expected event transfer.
  typedef struct {
    bcc_event_t ev;
    logic       pressed;
  } click_result_t;

  // The scoreboard carries its own copy of the button state and registers.
  // Every accepted sample is classified at once and the outcome is queued
  // until the matching event transfer shows up on the output channel.
  class click_scoreboard;
    logic [WINDOW_W-1:0] debounce;
    logic [WINDOW_W-1:0] window;
    logic                pressed_level;
    logic                pressed;
    logic [TIME_W-1:0]   press_time;
    logic [TIME_W-1:0]   release_time;
    logic                armed;
    logic                double_pending;
    click_result_t       expected_events[$];
    int unsigned         mismatches;

    function new();
      debounce       = DEBOUNCE_RESET;
      window         = DOUBLE_CLICK_RESET;
      pressed_level  = PRESSED_LEVEL_RESET;
      pressed        = 1'b0;
      press_time     = '0;
      release_time   = '0;
      armed          = 1'b0;
      double_pending = 1'b0;
      mismatches     = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_DEBOUNCE:      debounce = value;
        CFG_DOUBLE_CLICK:  window = value;
        CFG_PRESSED_LEVEL: pressed_level = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return expected_events.size();
    endfunction

    // Classifies one accepted sample. Later checks override the event of
    // earlier ones: window expiry, then press, then release.
    function void note_sample(logic level, logic [TIME_W-1:0] now, logic arm);
      logic              down;
      logic [TIME_W-1:0] since_release;
      logic [TIME_W-1:0] since_press;
      click_result_t     res;
      down   = (level == pressed_level);
      res.ev = EV_NONE;
      if (arm) armed = 1'b1;
      since_release = now - release_time;
      if (since_release > window && armed && !double_pending) begin
        armed  = 1'b0;
        res.ev = EV_SINGLE;
      end
      if (since_release >= debounce && down && !pressed) begin
        press_time     = now;
        pressed        = 1'b1;
        double_pending = armed && (since_release < window);
        res.ev         = EV_PRESSED;
      end
      since_press = now - press_time;
      if (since_press >= debounce && !down && pressed) begin
        release_time = now;
        pressed      = 1'b0;
        res.ev       = EV_RELEASED;
        if (double_pending) begin
          double_pending = 1'b0;
          armed          = 1'b0;
          res.ev         = EV_DOUBLE;
        end
      end
      res.pressed = pressed;
      expected_events.push_back(res);
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_event(logic [EVENT_W-1:0] ev, logic is_pressed);
      click_result_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("event %0d arrived with nothing outstanding", ev));
        return;
      end
      want = expected_events.pop_front();
      if (ev !== want.ev)
        report($sformatf("event_res %0d, expected %0d", ev, want.ev));
      if (is_pressed !== want.pressed)
        report($sformatf("is_pressed %b, expected %b", is_pressed, want.pressed));
    endtask
  endclass

  bit                      clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  bcc_in_if  in_ch ();
  bcc_out_if out_ch ();

  click_scoreboard sb;

  // Percentages of cycles in which the sender or the receiver sits idle.
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  // Set by the stimulus to make the receiver stall for HOLD_CYCLES.
  bit          hold_off_req;

  // Running state of the random sample generator.
  logic [TIME_W-1:0] stamp;
  logic              lvl;

  button_click_classifier DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // 4 ns clock; the first rising edge comes at 2 ns.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Every event transfer is checked at the rising edge that completes it.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_event(out_ch.event_res, out_ch.is_pressed);
  end

  // Receiver: ready changes only at falling edges. A hold-off request keeps
  // ready low for a long stretch, so the block fills and stalls its input.
  initial begin : receiver
    int unsigned held;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offers one sample, with random idle cycles first, and returns at the
  // falling edge after its transfer. Valid is left high so that back-to-back
  // samples keep the channel busy; the next call or the caller lowers it.
  task automatic send_sample(input logic level, input logic [TIME_W-1:0] now,
                             input logic arm);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.level      <= level;
    in_ch.now_ms     <= now;
    in_ch.arm_double <= arm;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(level, now, arm);
    @(negedge clk);
  endtask

  // Stops offering samples and waits until every outstanding event has been
  // delivered, plus a few cycles for the two pipeline registers to drain.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Holds one register write for a single cycle; the caller lowers the
  // write enable after the last write of a batch.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    sb.set_reg(idx, value);
  endtask

  // Registers are only rewritten once the block has gone idle.
  task automatic configure(input logic [WINDOW_W-1:0] debounce,
                           input logic [WINDOW_W-1:0] window,
                           input logic pressed_level);
    drain();
    write_reg(CFG_DEBOUNCE, debounce);
    write_reg(CFG_DOUBLE_CLICK, window);
    write_reg(CFG_PRESSED_LEVEL, {{(CFG_DATA_W-1){1'b0}}, pressed_level});
    cfg_we <= 1'b0;
  endtask

  // Random samples mostly follow a press/release rhythm: levels alternate and
  // timestamps step by amounts on the scale of the debounce time and the
  // double-click window, with many landing right on those boundaries as
  // measured from the last accepted edge. A few samples jump to an arbitrary
  // timestamp, which also puts time out of order.
  task automatic random_sample();
    logic [TIME_W-1:0] anchor;
    int unsigned       pick;
    pick   = $urandom_range(99);
    anchor = sb.pressed ? sb.press_time : sb.release_time;
    if (pick < 8)
      stamp = $urandom();
    else if (pick < 30)
      stamp = stamp + $urandom_range(0, sb.debounce);
    else if (pick < 60)
      stamp = stamp + $urandom_range(0, sb.debounce + sb.window + 2);
    else if (pick < 75)
      stamp = anchor + sb.debounce + $urandom_range(0, 2) - 1;
    else if (pick < 90)
      stamp = sb.release_time + sb.window + $urandom_range(0, 2) - 1;
    else
      stamp = stamp + $urandom_range(0, 200000);
    if ($urandom_range(99) < 70) lvl = ~lvl;
    send_sample(lvl, stamp, $urandom_range(99) < 25);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    sb               = new();
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = CFG_DEBOUNCE;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.level      = 1'b0;
    in_ch.now_ms     = '0;
    in_ch.arm_double = 1'b0;
    tx_idle_pct      = 0;
    rx_idle_pct      = 0;
    hold_off_req     = 1'b0;
    stamp            = '0;
    lvl              = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed samples under the reset registers: debounce 50, window 300,
    // pressed level 1.
    send_sample(1'b1, 32'd10, 1'b0);   // press inside the debounce time
    send_sample(1'b1, 32'd60, 1'b1);   // arm, then press inside the window
    send_sample(1'b0, 32'd80, 1'b0);   // release bounce, ignored
    send_sample(1'b0, 32'd120, 1'b0);  // release with a pending double
    send_sample(1'b0, 32'd150, 1'b1);  // arm while released
    send_sample(1'b0, 32'd420, 1'b0);  // exactly at the window: no expiry yet
    send_sample(1'b0, 32'd421, 1'b0);  // window expired: single
    send_sample(1'b1, 32'd500, 1'b1);  // press while armed, past the window
    send_sample(1'b0, 32'd600, 1'b0);  // plain release
    send_sample(1'b1, 32'hFFFF_FFF0, 1'b0);
    send_sample(1'b0, 32'hFFFF_FFFF, 1'b0);
    // The press time wraps past zero; 49 ms is still inside the debounce.
    send_sample(1'b0, 32'h0000_0021, 1'b0);
    send_sample(1'b0, 32'h0000_0022, 1'b0);
    // Time runs backwards: the difference wraps to a huge value.
    send_sample(1'b1, 32'h0000_0010, 1'b1);

    // Zero-width windows with an active-low button: every edge is taken and
    // no double is ever marked.
    configure(16'd0, 16'd0, 1'b0);
    send_sample(1'b0, 32'd5, 1'b1);
    send_sample(1'b1, 32'd5, 1'b1);
    send_sample(1'b0, 32'd5, 1'b1);
    send_sample(1'b1, 32'd5, 1'b0);

    // Widest windows, probed exactly at the limit and one millisecond below it.
    configure(16'hFFFF, 16'hFFFF, 1'b1);
    send_sample(1'b1, 32'd5 + 32'd65534, 1'b1);
    send_sample(1'b1, 32'd5 + 32'd65535, 1'b0);
    send_sample(1'b0, 32'd5 + 32'd131070, 1'b0);
    send_sample(1'b1, 32'd5 + 32'd196605, 1'b1);
    send_sample(1'b0, 32'd5 + 32'd262140, 1'b0);

    // Random phases. The first three idle the receiver heavily, the next
    // three the sender; the last two run flat out, and the first of them
    // opens with a long receiver hold-off while samples keep coming.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: configure(DEBOUNCE_RESET, DOUBLE_CLICK_RESET, PRESSED_LEVEL_RESET);
        1: configure(16'd0, 16'd0, 1'b0);
        2: configure(16'hFFFF, 16'hFFFF, 1'b1);
        3: configure(WINDOW_W'($urandom_range(0, 20)), WINDOW_W'($urandom_range(0, 60)),
                     1'($urandom_range(0, 1)));
        4: configure(16'd1, 16'd1, 1'b0);
        5: configure(WINDOW_W'($urandom_range(0, 65535)),
                     WINDOW_W'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)));
        6: configure(16'd0, 16'hFFFF, 1'b1);
        default: configure(16'hFFFF, 16'd0, 1'b0);
      endcase
      if (phase < 3) begin
        tx_idle_pct = 15;
        rx_idle_pct = 87;
      end else if (phase < 6) begin
        tx_idle_pct = 87;
        rx_idle_pct = 15;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (phase == 6) hold_off_req = 1'b1;
      for (n = 0; n < SAMPLES_PER_PHASE; n++) random_sample();
    end

    // Let the last events out, then a few more cycles in case anything
    // unexpected still trickles from the pipeline.
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // A stuck handshake ends the run here.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
